// ===== design/socks5_greeting_parser_unit_defines.svh =====
// Assertion macros shared by the greeting parser modules.
`ifndef SOCKS5_GREETING_PARSER_UNIT_DEFINES_SVH
`define SOCKS5_GREETING_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SGP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SGP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SGP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGP_ASSERT_ALWAYS(label, expr, msg)
`define SGP_ASSERT_SAME(label, ante, cons, msg)
`define SGP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/sgp_pkg.sv =====
// Types and constants of the SOCKS5 greeting parser.
`timescale 1ns / 1ps
`default_nettype none

package sgp_pkg;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COUNT   = 3'd1,
    PH_METHODS = 3'd2,
    PH_DONE    = 3'd3,
    PH_FAILED  = 3'd4
  } phase_t;

  localparam logic [7:0] SOCKS_VER  = 8'h05;
  localparam logic [7:0] M_NOAUTH   = 8'h00;
  localparam logic [7:0] M_USERPASS = 8'h02;
  localparam logic [7:0] M_NONE     = 8'hFF;

  localparam logic [1:0] NEXT_AUTH    = 2'd0;
  localparam logic [1:0] NEXT_REQUEST = 2'd1;
  localparam logic [1:0] NEXT_CLOSE   = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
    logic       is_last;
    logic [1:0] next_phase;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } emit_t;

endpackage

`default_nettype wire

// ===== design/sgp_core.sv =====
// Greeting parse state and the results produced by one input byte.
`timescale 1ns / 1ps
`default_nettype none

`include "socks5_greeting_parser_unit_defines.svh"

module sgp_core
  import sgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       new_session,
  input  logic       users_configured,
  output emit_t      emit
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] methods_left;
  logic [7:0] methods_left_next;
  logic       offered_userpass;
  logic       offered_userpass_next;
  logic       offered_noauth;
  logic       offered_noauth_next;

  phase_t     cur_phase;
  logic [7:0] cur_left;
  logic       cur_userpass;
  logic       cur_noauth;
  logic [7:0] left_dec;

  // A new session clears the parser before the byte is consumed.
  assign cur_phase    = new_session ? PH_VERSION : phase;
  assign cur_left     = new_session ? 8'd0 : methods_left;
  assign cur_userpass = new_session ? 1'b0 : offered_userpass;
  assign cur_noauth   = new_session ? 1'b0 : offered_noauth;
  assign left_dec     = cur_left - 8'd1;

  always_comb begin
    phase_next            = cur_phase;
    methods_left_next     = cur_left;
    offered_userpass_next = cur_userpass;
    offered_noauth_next   = cur_noauth;
    unique case (cur_phase)
      PH_VERSION: begin
        phase_next = (in_byte == SOCKS_VER) ? PH_COUNT : PH_FAILED;
      end
      PH_COUNT: begin
        methods_left_next = in_byte;
        phase_next = (in_byte == 8'd0) ? PH_DONE : PH_METHODS;
      end
      PH_METHODS: begin
        if (in_byte == M_NOAUTH) begin
          offered_noauth_next = 1'b1;
        end else if (in_byte == M_USERPASS) begin
          offered_userpass_next = 1'b1;
        end
        methods_left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic       bad_version;
    logic       completed;
    logic [7:0] method;
    logic [1:0] method_phase;
    bad_version = (cur_phase == PH_VERSION) && (in_byte != SOCKS_VER);
    completed   = ((cur_phase == PH_COUNT) && (in_byte == 8'd0)) ||
                  ((cur_phase == PH_METHODS) && (left_dec == 8'd0));
    if (offered_userpass_next) begin
      method       = M_USERPASS;
      method_phase = NEXT_AUTH;
    end else if (offered_noauth_next && !users_configured) begin
      method       = M_NOAUTH;
      method_phase = NEXT_REQUEST;
    end else begin
      method       = M_NONE;
      method_phase = NEXT_CLOSE;
    end
    emit.second = '{out_byte: method, is_error: 1'b0, is_last: 1'b1,
                    next_phase: method_phase};
    if (bad_version) begin
      emit.count = 2'd1;
      emit.first = '{out_byte: 8'd0, is_error: 1'b1, is_last: 1'b1,
                     next_phase: NEXT_CLOSE};
    end else begin
      emit.count = completed ? 2'd2 : 2'd0;
      emit.first = '{out_byte: SOCKS_VER, is_error: 1'b0, is_last: 1'b0,
                     next_phase: NEXT_AUTH};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_VERSION;
      methods_left     <= 8'd0;
      offered_userpass <= 1'b0;
      offered_noauth   <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      methods_left     <= methods_left_next;
      offered_userpass <= offered_userpass_next;
      offered_noauth   <= offered_noauth_next;
    end
  end

  `SGP_ASSERT_NEXT(a_error_fails, step && emit.first.is_error, phase == PH_FAILED, "Error result did not leave the parser failed.")
  `SGP_ASSERT_NEXT(a_reply_done, step && (emit.count == 2'd2), phase == PH_DONE, "Reply was sent but the greeting is not done.")
  `SGP_ASSERT_SAME(a_idle_silent, (phase == PH_DONE || phase == PH_FAILED) && !new_session, emit.count == 2'd0, "A byte after the greeting produced a result.")
  `SGP_ASSERT_SAME(a_count_range, step, emit.count != 2'd3, "More than two results from one byte.")

endmodule

`default_nettype wire

// ===== design/sgp_queue.sv =====
// Result queue that takes up to two results per cycle while it has room and returns one per pop.
`timescale 1ns / 1ps
`default_nettype none

`include "socks5_greeting_parser_unit_defines.svh"

module sgp_queue
  import sgp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  emit_t   push_data,
  output logic    room,
  output logic    head_valid,
  output result_t head,
  input  logic    pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] wr_ptr_plus1;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    push_n;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  assign push_n       = push ? push_data.count : 2'd0;
  assign do_pop       = pop && head_valid;
  assign wr_ptr_plus1 = ptr_inc(wr_ptr);
  assign head_valid   = (count != '0);
  assign head         = mem[rd_ptr];
  assign room         = (count <= CW'(DEPTH - 2));

  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_next = wr_ptr_plus1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CW'(push_n) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_data.first;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_plus1] <= push_data.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  `SGP_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "Result queue overflowed.")
  `SGP_ASSERT_SAME(a_push_room, push_n != 2'd0, room, "Results pushed without room.")
  `SGP_ASSERT_NEXT(a_pop_drains, do_pop && (push_n == 2'd0), count == $past(count) - CW'(1), "A pop did not lower the queue fill.")

endmodule

`default_nettype wire

// ===== design/socks5_greeting_parser_unit.sv =====
// Top level of the SOCKS5 client greeting parser.
// The unit accepts one greeting byte per clock cycle while in_ready is high and
// replies with an error transaction on a bad version, or with two transactions
// (0x05, then the chosen method) when the greeting completes. An accepted byte
// is held in an input register, parsed there and written into a small result
// queue once the queue has room; its results are offered from the queue head.
// The output port moves one transaction per cycle while out_ready is high,
// which sets the sustained rate: one byte per cycle while the queue has room,
// with a completed greeting occupying the output for two transactions. A
// byte is taken while the input register is empty or while the queue has room
// for the two results of the byte it holds. The users_configured register should
// be written while no byte is in flight; it is read when a greeting completes.
`timescale 1ns / 1ps
`default_nettype none

module socks5_greeting_parser_unit
  import sgp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       new_session,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_error,
  output logic       is_last,
  output logic [1:0] next_phase,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       users_configured
);

  logic       users_setting;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_new;
  logic       advance;
  logic       room;
  emit_t      emit;
  result_t    head;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && room;
  assign in_ready  = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      users_setting <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      users_setting <= users_configured;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_new  <= new_session;
    end
  end

  sgp_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .in_byte          (hold_byte),
    .new_session      (hold_new),
    .users_configured (users_setting),
    .emit             (emit)
  );

  sgp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_data  (emit),
    .room       (room),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_ready)
  );

  assign out_byte   = head.out_byte;
  assign is_error   = head.is_error;
  assign is_last    = head.is_last;
  assign next_phase = head.next_phase;

endmodule

`default_nettype wire
